// ===== rtl/core/cbpd_pkg.sv =====
// shared types, constants and tables of the caption byte pair decoder
`default_nettype none
package cbpd_pkg;

   localparam int ScreenRows    = 15;
   localparam int ScreenColumns = 32;
   localparam int RowW          = 4;
   localparam int ColW          = 5;
   localparam int CurColW       = 6;
   localparam int BankCells     = ScreenRows * ScreenColumns;
   localparam int Cells         = 2 * BankCells;
   localparam int AddrW         = 10;

   localparam logic [15:0] Blank     = 16'h0020;
   localparam logic [15:0] NoControl = 16'hFFFF;

   typedef enum logic [2:0] {
      OUT_IGNORED   = 3'd0,
      OUT_PARITY    = 3'd1,
      OUT_PADDING   = 3'd2,
      OUT_REPEAT    = 3'd3,
      OUT_OTHER     = 3'd4,
      OUT_EXECUTED  = 3'd5,
      OUT_READ      = 3'd6
   } outcome_type;

   typedef enum logic [1:0] {
      MODE_NONE   = 2'd0,
      MODE_POPON  = 2'd1,
      MODE_ROLLUP = 2'd2,
      MODE_PAINT  = 2'd3
   } cap_mode_type;

   // one request from the sequencer to the memory unit
   typedef struct packed {
      logic             wr;
      logic             rd;
      logic [AddrW-1:0] addr;
      logic [15:0]      wdata;
   } mem_req_type;

   // bank one starts right after bank zero
   function automatic logic [AddrW-1:0] cell_addr(input logic bank,
                                                  input logic [RowW-1:0] row,
                                                  input logic [ColW-1:0] col);
      logic [AddrW-1:0] a;
      a = (bank ? AddrW'(BankCells) : AddrW'(0))
          + AddrW'(row) * AddrW'(ScreenColumns) + AddrW'(col);
      return a;
   endfunction

   function automatic logic [15:0] basic_char(input logic [6:0] b);
      logic [15:0] r;
      unique case (b)
         7'h2A: r = 16'h00E1;
         7'h5C: r = 16'h00E9;
         7'h5E: r = 16'h00ED;
         7'h5F: r = 16'h00F3;
         7'h60: r = 16'h00FA;
         7'h7B: r = 16'h00E7;
         7'h7C: r = 16'h00F7;
         7'h7D: r = 16'h00D1;
         7'h7E: r = 16'h00F1;
         7'h7F: r = 16'h2588;
         default: r = {9'd0, b};
      endcase
      return r;
   endfunction

   function automatic logic [15:0] special_char(input logic [3:0] i);
      logic [15:0] r;
      unique case (i)
         4'd0: r = 16'h00AE;  4'd1: r = 16'h00B0;  4'd2: r = 16'h00BD;
         4'd3: r = 16'h00BF;  4'd4: r = 16'h2122;  4'd5: r = 16'h00A2;
         4'd6: r = 16'h00A3;  4'd7: r = 16'h266A;  4'd8: r = 16'h00E0;
         4'd9: r = 16'h0020;  4'd10: r = 16'h00E8; 4'd11: r = 16'h00E2;
         4'd12: r = 16'h00EA; 4'd13: r = 16'h00EE; 4'd14: r = 16'h00F4;
         default: r = 16'h00FB;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] ext_a(input logic [4:0] i);
      logic [15:0] r;
      unique case (i)
         5'd0: r = 16'h00C1;  5'd1: r = 16'h00C9;  5'd2: r = 16'h00D3;
         5'd3: r = 16'h00DA;  5'd4: r = 16'h00DC;  5'd5: r = 16'h00FC;
         5'd6: r = 16'h0027;  5'd7: r = 16'h00A1;  5'd8: r = 16'h002A;
         5'd9: r = 16'h0027;  5'd10: r = 16'h2014; 5'd11: r = 16'h00A9;
         5'd12: r = 16'h2120; 5'd13: r = 16'h2022; 5'd14: r = 16'h201C;
         5'd15: r = 16'h201D; 5'd16: r = 16'h00C0; 5'd17: r = 16'h00C2;
         5'd18: r = 16'h00C7; 5'd19: r = 16'h00C8; 5'd20: r = 16'h00CA;
         5'd21: r = 16'h00CB; 5'd22: r = 16'h00EB; 5'd23: r = 16'h00CE;
         5'd24: r = 16'h00CF; 5'd25: r = 16'h00EF; 5'd26: r = 16'h00D4;
         5'd27: r = 16'h00D9; 5'd28: r = 16'h00F9; 5'd29: r = 16'h00DB;
         5'd30: r = 16'h00AB;
         default: r = 16'h00BB;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] ext_b(input logic [4:0] i);
      logic [15:0] r;
      unique case (i)
         5'd0: r = 16'h00C3;  5'd1: r = 16'h00E3;  5'd2: r = 16'h00CD;
         5'd3: r = 16'h00CC;  5'd4: r = 16'h00EC;  5'd5: r = 16'h00D2;
         5'd6: r = 16'h00F2;  5'd7: r = 16'h00D5;  5'd8: r = 16'h00F5;
         5'd9: r = 16'h007B;  5'd10: r = 16'h007D; 5'd11: r = 16'h005C;
         5'd12: r = 16'h005E; 5'd13: r = 16'h005F; 5'd14: r = 16'h007C;
         5'd15: r = 16'h007E; 5'd16: r = 16'h00C4; 5'd17: r = 16'h00E4;
         5'd18: r = 16'h00D6; 5'd19: r = 16'h00F6; 5'd20: r = 16'h00DF;
         5'd21: r = 16'h00A5; 5'd22: r = 16'h00A4; 5'd23: r = 16'h007C;
         5'd24: r = 16'h00C5; 5'd25: r = 16'h00E5; 5'd26: r = 16'h00D8;
         5'd27: r = 16'h00F8; 5'd28: r = 16'h250C; 5'd29: r = 16'h2510;
         5'd30: r = 16'h2514;
         default: r = 16'h2518;
      endcase
      return r;
   endfunction

   // preamble row table, one based, zero means no row
   function automatic logic [4:0] pac_row(input logic [2:0] base, input logic hi);
      logic [4:0] r;
      unique case ({base, hi})
         4'b000_0: r = 5'd11; 4'b000_1: r = 5'd0;
         4'b001_0: r = 5'd1;  4'b001_1: r = 5'd2;
         4'b010_0: r = 5'd3;  4'b010_1: r = 5'd4;
         4'b011_0: r = 5'd12; 4'b011_1: r = 5'd13;
         4'b100_0: r = 5'd14; 4'b100_1: r = 5'd15;
         4'b101_0: r = 5'd5;  4'b101_1: r = 5'd6;
         4'b110_0: r = 5'd7;  4'b110_1: r = 5'd8;
         default:  r = {4'd4, hi} + 5'd1;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cbpd_screen_mem.sv =====
// both screen banks in one single port memory with registered read
`default_nettype none
module cbpd_screen_mem (
   input  wire logic                 clock,
   input  wire cbpd_pkg::mem_req_type req,
   output logic [15:0]               rdata
);
   import cbpd_pkg::*;

   logic [15:0] mem [Cells];

   always_ff @(posedge clock) begin
      if (req.wr) begin
         mem[req.addr] <= req.wdata;
      end
      if (req.rd) begin
         rdata <= mem[req.addr];
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/caption_byte_pair_decoder_unit.sv =====
// top level of the caption byte pair decoder
`default_nettype none
// Decodes caption byte pairs for the channel held in the csr register and
// keeps two 15x32 screen banks in one single port memory; a read transaction
// returns one cell of the displayed bank. After reset a clearing pass blanks
// both banks before the first request is taken. One transaction occupies the
// block until its result is taken: a plain pair passes from decode straight
// to the response, each character written adds a write state and a cell read
// adds a read and a wait state. Commands that walk the memory take longer: an
// erase blanks all 480 cells of a bank, delete to end up to 32 cells, and a
// carriage return reads, waits and writes for every copied cell, then blanks
// one row. The single memory port serialises these walks.
module caption_byte_pair_decoder_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_channel_select,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_mode,
   input  wire logic        req_pair_valid,
   input  wire logic [1:0]  req_pair_kind,
   input  wire logic [7:0]  req_first_byte,
   input  wire logic [7:0]  req_second_byte,
   input  wire logic [3:0]  req_read_row,
   input  wire logic [4:0]  req_read_column,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_outcome,
   output logic             rsp_display_update,
   output logic [1:0]       rsp_caption_mode,
   output logic [15:0]      rsp_cell_value,
   output logic [15:0]      rsp_parity_error_count,
   output logic [3:0]       rsp_cursor_row,
   output logic [5:0]       rsp_cursor_column,
   output logic             rsp_underline_on,
   output logic             rsp_italic_on,
   output logic             rsp_captions_seen
);
   import cbpd_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DECODE, ST_PUT, ST_CLRBANK, ST_DELEND,
      ST_CRREAD, ST_CRWAIT, ST_CRWRITE, ST_CRBLANK, ST_READ, ST_READWAIT, ST_RESP
   } state_type;

   state_type        state_ff;
   logic [AddrW-1:0] sweep_ff;        // clearing pass / bank erase counter
   logic             bank_ff;         // bank under erase
   logic [1:0]       chan_ff;
   logic             shown_ff;
   logic [1:0]       mode_ff;
   logic [3:0]       row_ff;
   logic [5:0]       col_ff;
   logic [2:0]       depth_ff;
   logic             ul_ff, it_ff, second_ff, seen_ff, pub_ff;
   logic [15:0]      prev_ff;
   logic [15:0]      tally_ff;
   logic [2:0]       outc_ff;
   logic [15:0]      cell_ff;
   logic [15:0]      char_ff;         // character waiting to be written
   logic             char2_ff;        // backspace write, cursor held
   logic             char2ok_ff;
   logic [6:0]       b2_ff;
   logic [3:0]       crrow_ff;        // carriage return walking row
   logic [5:0]       crcol_ff;
   logic [3:0]       rrow_ff;
   logic [4:0]       rcol_ff;
   logic             mode_in_ff;
   logic             pv_ff;
   logic [1:0]       kind_ff;
   logic [7:0]       d1_ff, d2_ff;

   mem_req_type      mreq;
   logic [15:0]      rdata;

   cbpd_screen_mem u_mem (.clock(clock), .req(mreq), .rdata(rdata));

   assign csr_ready = (state_ff != ST_RESP) && !(state_ff == ST_IDLE && req_valid);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

   assign rsp_outcome            = outc_ff;
   assign rsp_display_update     = pub_ff;
   assign rsp_caption_mode       = mode_ff;
   assign rsp_cell_value         = cell_ff;
   assign rsp_parity_error_count = tally_ff;
   assign rsp_cursor_row         = row_ff;
   assign rsp_cursor_column      = col_ff;
   assign rsp_underline_on       = ul_ff;
   assign rsp_italic_on          = it_ff;
   assign rsp_captions_seen      = seen_ff;

   // write target bank follows the caption mode
   logic tgt_bank;
   assign tgt_bank = (mode_ff == MODE_POPON) ? ~shown_ff : shown_ff;

   // decode helpers
   logic       p1, p2;
   logic [6:0] b1, b2;
   logic [6:0] base;
   assign p1   = ^d1_ff;
   assign p2   = ^d2_ff;
   assign b1   = d1_ff[6:0];
   assign b2   = d2_ff[6:0];
   assign base = b1 & 7'h77;

   logic [4:0] prow;
   assign prow = pac_row(base[2:0], b2 >= 7'h60);

   logic [6:0] tabcol;
   assign tabcol = {1'b0, col_ff} + {5'd0, b2[1:0]};

   logic [3:0] crtop;
   assign crtop = ({1'b0, row_ff} + 5'd1 >= {2'b0, depth_ff})
                  ? 4'(row_ff + 4'd1 - {1'b0, depth_ff}) : 4'd0;

   always_comb begin
      mreq = '0;
      unique case (state_ff)
         ST_CLEAR, ST_CLRBANK: begin
            mreq.wr    = 1'b1;
            mreq.addr  = (state_ff == ST_CLEAR) ? sweep_ff
                         : (bank_ff ? AddrW'(BankCells) : AddrW'(0)) + sweep_ff;
            mreq.wdata = Blank;
         end
         ST_PUT: begin
            mreq.wr    = (col_ff < 6'(ScreenColumns)) && (row_ff < 4'(ScreenRows));
            mreq.addr  = cell_addr(tgt_bank, row_ff, col_ff[4:0]);
            mreq.wdata = char_ff;
         end
         ST_DELEND: begin
            mreq.wr    = 1'b1;
            mreq.addr  = cell_addr(tgt_bank, row_ff, crcol_ff[4:0]);
            mreq.wdata = Blank;
         end
         ST_CRREAD: begin
            mreq.rd   = 1'b1;
            mreq.addr = cell_addr(shown_ff, 4'(crrow_ff + 4'd1), crcol_ff[4:0]);
         end
         ST_CRWRITE: begin
            mreq.wr    = 1'b1;
            mreq.addr  = cell_addr(shown_ff, crrow_ff, crcol_ff[4:0]);
            mreq.wdata = rdata;
         end
         ST_CRBLANK: begin
            mreq.wr    = 1'b1;
            mreq.addr  = cell_addr(shown_ff, row_ff, crcol_ff[4:0]);
            mreq.wdata = Blank;
         end
         ST_READ: begin
            mreq.rd   = 1'b1;
            mreq.addr = cell_addr(shown_ff, rrow_ff, rcol_ff);
         end
         default: mreq = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         sweep_ff   <= '0;
         chan_ff    <= '0;
         shown_ff   <= 1'b0;
         mode_ff    <= MODE_NONE;
         row_ff     <= 4'(ScreenRows - 1);
         col_ff     <= '0;
         depth_ff   <= 3'd2;
         ul_ff      <= 1'b0;
         it_ff      <= 1'b0;
         second_ff  <= 1'b0;
         seen_ff    <= 1'b0;
         pub_ff     <= 1'b0;
         prev_ff    <= NoControl;
         tally_ff   <= '0;
         char2_ff   <= 1'b0;
         char2ok_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            chan_ff <= csr_channel_select;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == AddrW'(Cells - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  mode_in_ff <= req_mode;
                  pv_ff      <= req_pair_valid;
                  kind_ff    <= req_pair_kind;
                  d1_ff      <= req_first_byte;
                  d2_ff      <= req_second_byte;
                  rrow_ff    <= req_read_row;
                  rcol_ff    <= req_read_column;
                  pub_ff     <= 1'b0;
                  cell_ff    <= '0;
                  char2_ff   <= 1'b0;
                  state_ff   <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               state_ff <= ST_RESP;
               outc_ff  <= OUT_EXECUTED;
               if (mode_in_ff) begin
                  outc_ff <= OUT_READ;
                  if (rrow_ff < 4'(ScreenRows)) begin
                     state_ff <= ST_READ;
                  end
               end else if (!pv_ff || kind_ff[1]
                            || (kind_ff[0] != chan_ff[1])) begin
                  outc_ff <= OUT_IGNORED;
               end else if (!p1 || !p2) begin
                  outc_ff <= OUT_PARITY;
                  if ((d1_ff != 8'd0 || d2_ff != 8'd0) && tally_ff != 16'hFFFF) begin
                     tally_ff <= tally_ff + 16'd1;
                  end
               end else if (b1 == 7'd0 && b2 == 7'd0) begin
                  outc_ff <= OUT_PADDING;
                  prev_ff <= NoControl;
               end else if (b1[6:4] == 3'b001) begin
                  // control pair
                  if ({1'b0, b1, 1'b0, b2} == prev_ff) begin
                     prev_ff <= NoControl;
                     outc_ff <= OUT_REPEAT;
                  end else begin
                     prev_ff   <= {1'b0, b1, 1'b0, b2};
                     second_ff <= b1[3];
                     if (b1[3] != chan_ff[0]) begin
                        outc_ff <= OUT_OTHER;
                     end else begin
                        seen_ff <= 1'b1;
                        if (b2 >= 7'h40) begin
                           if (prow != 5'd0) begin
                              row_ff <= 4'(prow - 5'd1);
                              ul_ff  <= b2[0];
                              if (b2[4]) begin
                                 col_ff <= {1'b0, b2[3:1], 2'b00};
                                 it_ff  <= 1'b0;
                              end else begin
                                 col_ff <= '0;
                                 it_ff  <= (b2[4:1] == 4'd7);
                              end
                           end
                        end else if (base == 7'h11 && b2 >= 7'h20 && b2 <= 7'h2F) begin
                           it_ff    <= (b2[3:1] == 3'b111);
                           ul_ff    <= b2[0];
                           char_ff  <= Blank;
                           pub_ff   <= 1'b1;
                           state_ff <= ST_PUT;
                        end else if (base == 7'h11 && b2 >= 7'h30) begin
                           char_ff  <= special_char(b2[3:0]);
                           pub_ff   <= 1'b1;
                           state_ff <= ST_PUT;
                        end else if ((base == 7'h12 || base == 7'h13) && b2 >= 7'h20) begin
                           char_ff  <= base[0] ? ext_b(b2[4:0]) : ext_a(b2[4:0]);
                           if (col_ff != 6'd0) col_ff <= col_ff - 6'd1;
                           pub_ff   <= 1'b1;
                           state_ff <= ST_PUT;
                        end else if (base == 7'h17 && b2 >= 7'h21 && b2 <= 7'h23) begin
                           col_ff <= (tabcol < 7'(ScreenColumns - 1))
                                     ? tabcol[5:0] : 6'(ScreenColumns - 1);
                        end else if (base == 7'h14 || base == 7'h15) begin
                           unique case (b2)
                              7'h20: mode_ff <= MODE_POPON;
                              7'h21: begin
                                 if (col_ff != 6'd0) begin
                                    col_ff   <= col_ff - 6'd1;
                                    char_ff  <= Blank;
                                    char2_ff <= 1'b1;  // do not advance
                                    pub_ff   <= 1'b1;
                                    state_ff <= ST_PUT;
                                 end
                              end
                              7'h24: begin
                                 pub_ff   <= 1'b1;
                                 crcol_ff <= col_ff;
                                 if (row_ff < 4'(ScreenRows)
                                     && col_ff < 6'(ScreenColumns)) begin
                                    state_ff <= ST_DELEND;
                                 end
                              end
                              7'h25, 7'h26, 7'h27: begin
                                 mode_ff  <= MODE_ROLLUP;
                                 depth_ff <= 3'(b2[2:0] - 3'd3);
                                 col_ff   <= '0;
                              end
                              7'h29: mode_ff <= MODE_PAINT;
                              7'h2C: begin
                                 pub_ff   <= 1'b1;
                                 bank_ff  <= shown_ff;
                                 sweep_ff <= '0;
                                 state_ff <= ST_CLRBANK;
                              end
                              7'h2D: begin
                                 if (mode_ff == MODE_ROLLUP
                                     && row_ff < 4'(ScreenRows)) begin
                                    col_ff   <= '0;
                                    pub_ff   <= 1'b1;
                                    crrow_ff <= crtop;
                                    crcol_ff <= '0;
                                    state_ff <= (crtop < row_ff) ? ST_CRREAD
                                                                 : ST_CRBLANK;
                                 end
                              end
                              7'h2E: begin
                                 bank_ff  <= ~shown_ff;
                                 sweep_ff <= '0;
                                 state_ff <= ST_CLRBANK;
                              end
                              7'h2F: begin
                                 shown_ff <= ~shown_ff;
                                 bank_ff  <= shown_ff;
                                 pub_ff   <= 1'b1;
                                 sweep_ff <= '0;
                                 state_ff <= ST_CLRBANK;
                              end
                              default: ;
                           endcase
                        end
                     end
                  end
               end else begin
                  // text pair
                  prev_ff <= NoControl;
                  if (second_ff != chan_ff[0]) begin
                     outc_ff <= OUT_OTHER;
                  end else begin
                     seen_ff <= 1'b1;
                     pub_ff  <= 1'b1;
                     char2ok_ff <= 1'b0;
                     if (b1 >= 7'h20) begin
                        char_ff  <= basic_char(b1);
                        state_ff <= ST_PUT;
                        if (b2 >= 7'h20) begin
                           b2_ff      <= b2;
                           char2ok_ff <= 1'b1;
                        end
                     end else if (b2 >= 7'h20) begin
                        char_ff  <= basic_char(b2);
                        state_ff <= ST_PUT;
                     end
                  end
               end
            end
            ST_PUT: begin
               // backspace write keeps the cursor in place
               if (!char2_ff && mreq.wr) begin
                  col_ff <= col_ff + 6'd1;
               end
               char2_ff <= 1'b0;
               if (char2ok_ff) begin
                  char2ok_ff <= 1'b0;
                  char_ff    <= basic_char(b2_ff);
               end else begin
                  state_ff <= ST_RESP;
               end
            end
            ST_CLRBANK: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == AddrW'(ScreenRows * ScreenColumns - 1)) begin
                  state_ff <= ST_RESP;
               end
            end
            ST_DELEND: begin
               crcol_ff <= crcol_ff + 6'd1;
               if (crcol_ff == 6'(ScreenColumns - 1)) begin
                  state_ff <= ST_RESP;
               end
            end
            ST_CRREAD:  state_ff <= ST_CRWAIT;
            ST_CRWAIT:  state_ff <= ST_CRWRITE;
            ST_CRWRITE: begin
               state_ff <= ST_CRREAD;
               if (crcol_ff == 6'(ScreenColumns - 1)) begin
                  crcol_ff <= '0;
                  crrow_ff <= crrow_ff + 4'd1;
                  if (crrow_ff + 4'd1 == row_ff) begin
                     state_ff <= ST_CRBLANK;
                  end
               end else begin
                  crcol_ff <= crcol_ff + 6'd1;
               end
            end
            ST_CRBLANK: begin
               crcol_ff <= crcol_ff + 6'd1;
               if (crcol_ff == 6'(ScreenColumns - 1)) begin
                  state_ff <= ST_RESP;
               end
            end
            ST_READ:     state_ff <= ST_READWAIT;
            ST_READWAIT: begin
               cell_ff  <= rdata;
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               if (rsp_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== tb/sv/cbpd_checker.sv =====
// checker for the caption byte pair decoder: mirrors its state, predicts each response, compares
module cbpd_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [1:0]  csr_channel_select,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic        req_mode,
   input  wire logic        req_pair_valid,
   input  wire logic [1:0]  req_pair_kind,
   input  wire logic [7:0]  req_first_byte,
   input  wire logic [7:0]  req_second_byte,
   input  wire logic [3:0]  req_read_row,
   input  wire logic [4:0]  req_read_column,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [2:0]  rsp_outcome,
   input  wire logic        rsp_display_update,
   input  wire logic [1:0]  rsp_caption_mode,
   input  wire logic [15:0] rsp_cell_value,
   input  wire logic [15:0] rsp_parity_error_count,
   input  wire logic [3:0]  rsp_cursor_row,
   input  wire logic [5:0]  rsp_cursor_column,
   input  wire logic        rsp_underline_on,
   input  wire logic        rsp_italic_on,
   input  wire logic        rsp_captions_seen,
   output int               error_count,
   output int               pending_count
);
   import cbpd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      outcome_type  outcome;
      logic         update;
      cap_mode_type cmode;
      logic [15:0]  cell_val;
      logic [15:0]  tally;
      logic [3:0]   row;
      logic [5:0]   col;
      logic         ul;
      logic         it;
      logic         seen;
   } screen_status_type;

   localparam int NR = ScreenRows;
   localparam int NC = ScreenColumns;

   screen_status_type status_q[$];
   logic [15:0] bank[2][NR*NC];
   logic [1:0]  chan;
   logic        shown_sel;
   cap_mode_type cmode;
   int          row_cur, col_cur, depth;
   logic        ul_flag, it_flag, ch2_flag, seen_flag, updated;
   logic [15:0] last_ctrl, tally;

   function automatic logic [15:0] lookup_special(int i);
      logic [15:0] t[16] = '{16'hAE, 16'hB0, 16'hBD, 16'hBF, 16'h2122, 16'hA2, 16'hA3,
         16'h266A, 16'hE0, 16'h20, 16'hE8, 16'hE2, 16'hEA, 16'hEE, 16'hF4, 16'hFB};
      return t[i];
   endfunction

   function automatic logic [15:0] lookup_ext(logic second_set, int i);
      logic [15:0] a[32] = '{16'hC1, 16'hC9, 16'hD3, 16'hDA, 16'hDC, 16'hFC, 16'h27,
         16'hA1, 16'h2A, 16'h27, 16'h2014, 16'hA9, 16'h2120, 16'h2022, 16'h201C,
         16'h201D, 16'hC0, 16'hC2, 16'hC7, 16'hC8, 16'hCA, 16'hCB, 16'hEB, 16'hCE,
         16'hCF, 16'hEF, 16'hD4, 16'hD9, 16'hF9, 16'hDB, 16'hAB, 16'hBB};
      logic [15:0] b[32] = '{16'hC3, 16'hE3, 16'hCD, 16'hCC, 16'hEC, 16'hD2, 16'hF2,
         16'hD5, 16'hF5, 16'h7B, 16'h7D, 16'h5C, 16'h5E, 16'h5F, 16'h7C, 16'h7E,
         16'hC4, 16'hE4, 16'hD6, 16'hF6, 16'hDF, 16'hA5, 16'hA4, 16'h7C, 16'hC5,
         16'hE5, 16'hD8, 16'hF8, 16'h250C, 16'h2510, 16'h2514, 16'h2518};
      return second_set ? b[i] : a[i];
   endfunction

   function automatic logic [15:0] plain_glyph(logic [6:0] b);
      case (b)
         7'h2A: return 16'hE1;
         7'h5C: return 16'hE9;
         7'h5E: return 16'hED;
         7'h5F: return 16'hF3;
         7'h60: return 16'hFA;
         7'h7B: return 16'hE7;
         7'h7C: return 16'hF7;
         7'h7D: return 16'hD1;
         7'h7E: return 16'hF1;
         7'h7F: return 16'h2588;
         default: return {9'd0, b};
      endcase
   endfunction

   // pop-on paints the hidden bank, everything else the shown one
   function automatic logic write_bank();
      return (cmode == MODE_POPON) ? ~shown_sel : shown_sel;
   endfunction

   function automatic void blank_bank(logic which);
      for (int i = 0; i < NR*NC; i++) begin
         bank[which][i] = Blank;
      end
   endfunction

   function automatic void place_glyph(logic [15:0] c);
      if (row_cur >= NR || col_cur >= NC) return;
      bank[write_bank()][row_cur*NC + col_cur] = c;
      col_cur++;
   endfunction

   function automatic void apply_preamble(logic [6:0] b1, logic [6:0] b2);
      int pr[8][2] = '{'{11, 0}, '{1, 2}, '{3, 4}, '{12, 13}, '{14, 15}, '{5, 6},
         '{7, 8}, '{9, 10}};
      int r, sty;
      r = pr[b1[2:0]][b2 >= 7'h60];
      sty = (b2 >> 1) & 15;
      if (r == 0) return;
      row_cur = r - 1;
      ul_flag = b2[0];
      if (b2[4]) begin
         col_cur = ((sty & 7) * 4 < NC - 1) ? (sty & 7) * 4 : NC - 1;
         it_flag = 0;
      end else begin
         col_cur = 0;
         it_flag = (sty == 7);
      end
   endfunction

   function automatic void scroll_up();
      int top;
      if (cmode != MODE_ROLLUP || row_cur >= NR) return;
      top = (row_cur + 1 >= depth) ? row_cur + 1 - depth : 0;
      for (int r = top; r < row_cur; r++) begin
         for (int c = 0; c < NC; c++) begin
            bank[shown_sel][r*NC + c] = bank[shown_sel][(r+1)*NC + c];
         end
      end
      for (int c = 0; c < NC; c++) begin
         bank[shown_sel][row_cur*NC + c] = Blank;
      end
      col_cur = 0;
      updated = 1;
   endfunction

   function automatic void run_command(logic [6:0] b2);
      case (b2)
         7'h20: cmode = MODE_POPON;
         7'h21: begin
            if (col_cur > 0) begin
               col_cur--;
               if (row_cur < NR && col_cur < NC) begin
                  bank[write_bank()][row_cur*NC + col_cur] = Blank;
               end
               updated = 1;
            end
         end
         7'h24: begin
            if (row_cur < NR) begin
               for (int c = col_cur; c < NC; c++) begin
                  bank[write_bank()][row_cur*NC + c] = Blank;
               end
            end
            updated = 1;
         end
         7'h25, 7'h26, 7'h27: begin
            cmode = MODE_ROLLUP;
            depth = b2 - 7'h23;
            col_cur = 0;
         end
         7'h29: cmode = MODE_PAINT;
         7'h2C: begin
            blank_bank(shown_sel);
            updated = 1;
         end
         7'h2D: scroll_up();
         7'h2E: blank_bank(~shown_sel);
         7'h2F: begin
            shown_sel = ~shown_sel;
            blank_bank(~shown_sel);
            updated = 1;
         end
         default: ;
      endcase
   endfunction

   function automatic outcome_type decode_control(logic [6:0] b1, logic [6:0] b2);
      logic [6:0] base;
      int nc;
      base = b1 & 7'h77;
      if ({1'b0, b1, 1'b0, b2} == last_ctrl) begin
         last_ctrl = NoControl;
         return OUT_REPEAT;
      end
      last_ctrl = {1'b0, b1, 1'b0, b2};
      ch2_flag = b1[3];
      if (ch2_flag != chan[0]) return OUT_OTHER;
      seen_flag = 1;
      if (b2 >= 7'h40) begin
         apply_preamble(base, b2);
      end else if (base == 7'h11 && b2 >= 7'h20 && b2 <= 7'h2F) begin
         it_flag = (b2 & 7'h0E) == 7'h0E;
         ul_flag = b2[0];
         place_glyph(Blank);
         updated = 1;
      end else if (base == 7'h11 && b2 >= 7'h30) begin
         place_glyph(lookup_special(b2 - 7'h30));
         updated = 1;
      end else if ((base == 7'h12 || base == 7'h13) && b2 >= 7'h20) begin
         if (col_cur > 0) col_cur--;
         place_glyph(lookup_ext(base == 7'h13, b2 - 7'h20));
         updated = 1;
      end else if (base == 7'h17 && b2 >= 7'h21 && b2 <= 7'h23) begin
         nc = col_cur + (b2 - 7'h20);
         col_cur = (nc < NC - 1) ? nc : NC - 1;
      end else if (base == 7'h14 || base == 7'h15) begin
         run_command(b2);
      end
      return OUT_EXECUTED;
   endfunction

   function automatic outcome_type decode_pair(logic pv, logic [1:0] kind,
                                               logic [7:0] d1, logic [7:0] d2);
      logic [6:0] b1, b2;
      if (!pv || kind > 1) return OUT_IGNORED;
      if (kind[0] != chan[1]) return OUT_IGNORED;
      if (!(^d1) || !(^d2)) begin
         if ((d1 != 0 || d2 != 0) && tally != 16'hFFFF) tally++;
         return OUT_PARITY;
      end
      b1 = d1[6:0];
      b2 = d2[6:0];
      if (b1 == 0 && b2 == 0) begin
         last_ctrl = NoControl;
         return OUT_PADDING;
      end
      if (b1 >= 7'h10 && b1 <= 7'h1F) return decode_control(b1, b2);
      last_ctrl = NoControl;
      if (ch2_flag != chan[0]) return OUT_OTHER;
      seen_flag = 1;
      if (b1 >= 7'h20) place_glyph(plain_glyph(b1));
      if (b2 >= 7'h20) place_glyph(plain_glyph(b2));
      updated = 1;
      return OUT_EXECUTED;
   endfunction

   task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         error_count++;
      end
   endtask

   assign pending_count = status_q.size();

   always @(posedge clock) begin
      screen_status_type s, e;
      if (reset) begin
         status_q.delete();
         blank_bank(0);
         blank_bank(1);
         chan = 0;
         shown_sel = 0;
         cmode = MODE_NONE;
         row_cur = NR - 1;
         col_cur = 0;
         depth = 2;
         ul_flag = 0;
         it_flag = 0;
         ch2_flag = 0;
         seen_flag = 0;
         last_ctrl = NoControl;
         tally = 0;
         error_count = 0;
      end else begin
         if (csr_valid && csr_ready) chan = csr_channel_select;
         if (req_valid && req_ready) begin
            updated = 0;
            s.cell_val = 0;
            if (req_mode) begin
               if (req_read_row < NR && req_read_column < NC) begin
                  s.cell_val = bank[shown_sel][req_read_row*NC + req_read_column];
               end
               s.outcome = OUT_READ;
            end else begin
               s.outcome = decode_pair(req_pair_valid, req_pair_kind,
                                       req_first_byte, req_second_byte);
            end
            s.update = updated;
            s.cmode = cmode;
            s.tally = tally;
            s.row = row_cur[3:0];
            s.col = col_cur[5:0];
            s.ul = ul_flag;
            s.it = it_flag;
            s.seen = seen_flag;
            status_q = {status_q, s};
         end
         if (rsp_valid && rsp_ready) begin
            if (status_q.size() == 0) begin
               $error("response with no transaction outstanding");
               error_count++;
            end else begin
               e = status_q.pop_front();
               check_field("outcome", e.outcome, rsp_outcome);
               check_field("display_update", e.update, rsp_display_update);
               check_field("caption_mode", e.cmode, rsp_caption_mode);
               check_field("cell_value", e.cell_val, rsp_cell_value);
               check_field("parity_error_count", e.tally, rsp_parity_error_count);
               check_field("cursor_row", e.row, rsp_cursor_row);
               check_field("cursor_column", e.col, rsp_cursor_column);
               check_field("underline_on", e.ul, rsp_underline_on);
               check_field("italic_on", e.it, rsp_italic_on);
               check_field("captions_seen", e.seen, rsp_captions_seen);
            end
         end
      end
   end
endmodule

// ===== tb/sv/tb_top.sv =====
// top of the caption byte pair decoder testbench: stimulus, clock, reset and verdict
module tb_top;
   import cbpd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_valid = 0, csr_ready;
   logic [1:0]  csr_channel_select = 0;
   logic        req_valid = 0, req_ready;
   logic        req_mode = 0, req_pair_valid = 0;
   logic [1:0]  req_pair_kind = 0;
   logic [7:0]  req_first_byte = 0, req_second_byte = 0;
   logic [3:0]  req_read_row = 0;
   logic [4:0]  req_read_column = 0;
   logic        rsp_valid, rsp_ready = 0;
   logic [2:0]  rsp_outcome;
   logic        rsp_display_update;
   logic [1:0]  rsp_caption_mode;
   logic [15:0] rsp_cell_value, rsp_parity_error_count;
   logic [3:0]  rsp_cursor_row;
   logic [5:0]  rsp_cursor_column;
   logic        rsp_underline_on, rsp_italic_on, rsp_captions_seen;
   int          error_count, pending_count;
   logic        stall_enable = 1;

   always #4 clock = ~clock;

   caption_byte_pair_decoder_unit u_dut (.*);
   cbpd_checker u_checker (.*);

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int p;
      p = $urandom_range(99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 5);
   endfunction

   // response side back-pressure
   always @(negedge clock) begin
      rsp_ready <= stall_enable ? ($urandom_range(3) != 0) : 1'b1;
   end

   // put odd parity in bit 7
   function automatic logic [7:0] with_parity(logic [6:0] b);
      return {~(^b), b};
   endfunction

   // valid stays high into the next transaction when there is no gap
   task automatic send_transaction(logic md, logic pv, logic [1:0] kind, logic [7:0] d1,
                                   logic [7:0] d2, logic [3:0] rr, logic [4:0] rc);
      int gap;
      gap = gap_len();
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_mode <= md;
      req_pair_valid <= pv;
      req_pair_kind <= kind;
      req_first_byte <= d1;
      req_second_byte <= d2;
      req_read_row <= rr;
      req_read_column <= rc;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // a pair on the field of the current channel, parity correct
   task automatic send_pair(logic [1:0] chsel, logic [6:0] b1, logic [6:0] b2);
      send_transaction(1'b0, 1'b1, {1'b0, chsel[1]}, with_parity(b1), with_parity(b2),
                       4'($urandom), 5'($urandom));
   endtask

   // control code on the selected data channel, sent doubled three times in four, as broadcasters do
   task automatic send_control(logic [1:0] chsel, logic [6:0] b1, logic [6:0] b2);
      logic [6:0] c;
      c = b1 | (chsel[0] ? 7'h08 : 7'h00);
      send_pair(chsel, c, b2);
      if ($urandom_range(3) != 0) send_pair(chsel, c, b2);
   endtask

   task automatic read_cell();
      send_transaction(1'b1, 1'($urandom), 2'($urandom), 8'($urandom), 8'($urandom),
                       4'($urandom_range(15)), 5'($urandom));
   endtask

   // drop valid, wait until no transaction is outstanding, then a quiet stretch
   task automatic drain();
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (1200) @(negedge clock);
   endtask

   task automatic write_channel(logic [1:0] v);
      drain();
      csr_valid <= 1;
      csr_channel_select <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic random_item(logic [1:0] chsel);
      int p;
      logic [6:0] misc[10] = '{7'h20, 7'h21, 7'h24, 7'h25, 7'h26, 7'h27, 7'h29,
                               7'h2C, 7'h2D, 7'h2F};
      p = $urandom_range(99);
      if (p < 30) send_pair(chsel, 7'($urandom_range(127, 32)), 7'($urandom_range(127, 0)));
      else if (p < 45) send_control(chsel, 7'h14 | 7'($urandom_range(1)),
                                    misc[$urandom_range(9)]);
      else if (p < 55) send_control(chsel, 7'($urandom_range(7'h17, 7'h10)),
                                    7'($urandom_range(127, 64)));
      else if (p < 65) send_control(chsel, 7'($urandom_range(7'h13, 7'h11)),
                                    7'($urandom_range(63, 32)));
      else if (p < 70) send_control(chsel, 7'h17, 7'($urandom_range(7'h23, 7'h20)));
      else if (p < 78) read_cell();
      else if (p < 82) send_pair(chsel, 7'd0, 7'd0);
      else if (p < 85) send_control(chsel, 7'h14, 7'h2E);
      else send_transaction(1'b0, 1'($urandom), 2'($urandom), 8'($urandom), 8'($urandom),
                            4'($urandom), 5'($urandom));
   endtask

   initial begin
      logic [1:0] chsel;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: channel 1 pop-on caption, flip, reads and special cases
      chsel = 0;
      send_transaction(1'b0, 1'b0, 2'd0, 8'h80, 8'h80, 4'd0, 5'd0);
      send_transaction(1'b0, 1'b1, 2'd2, 8'hFF, 8'hFF, 4'd0, 5'd0);
      send_transaction(1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 4'd0, 5'd0);
      send_transaction(1'b0, 1'b1, 2'd0, 8'h41, 8'h42, 4'd0, 5'd0);
      send_pair(chsel, 7'd0, 7'd0);
      send_control(chsel, 7'h14, 7'h20);
      send_control(chsel, 7'h11, 7'h7F);
      send_pair(chsel, 7'h7F, 7'h2A);
      send_control(chsel, 7'h11, 7'h3F);
      send_control(chsel, 7'h12, 7'h3F);
      send_control(chsel, 7'h13, 7'h20);
      send_control(chsel, 7'h17, 7'h23);
      send_control(chsel, 7'h14, 7'h2F);
      send_transaction(1'b1, 1'b0, 2'd0, 8'd0, 8'd0, 4'd15, 5'd31);
      send_transaction(1'b1, 1'b0, 2'd0, 8'd0, 8'd0, 4'd14, 5'd0);
      send_control(chsel, 7'h14, 7'h25);
      send_pair(chsel, 7'h41, 7'h42);
      send_control(chsel, 7'h14, 7'h2D);
      send_control(chsel, 7'h14, 7'h21);
      send_control(chsel, 7'h14, 7'h24);
      send_control(chsel, 7'h1C, 7'h2C);
      send_control(chsel, 7'h14, 7'h2C);
      for (int i = 0; i < 20; i++) send_pair(chsel, 7'h5A, 7'h60);

      for (int ph = 0; ph < 6; ph++) begin
         chsel = (ph < 4) ? ph[1:0] : 2'($urandom_range(3));
         stall_enable = (ph != 2);
         write_channel(chsel);
         for (int i = 0; i < 190; i++) begin
            // occasional pair on the wrong data channel to hit the other-channel path
            random_item(($urandom_range(9) == 0) ? chsel ^ 2'b01 : chsel);
         end
      end

      drain();
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("tb_top: errors");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/core/cbpd_pkg.sv
rtl/core/cbpd_screen_mem.sv
rtl/core/caption_byte_pair_decoder_unit.sv
tb/sv/cbpd_checker.sv
tb/sv/tb_top.sv
